// ===== src/step_string_escape_encoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// step_string_escape_encoder_top_defines
// Assertion macros shared by the encoder's checker.
// ----------------------------------------------------------------------------
`ifndef STEP_STRING_ESCAPE_ENCODER_TOP_DEFINES_SVH
`define STEP_STRING_ESCAPE_ENCODER_TOP_DEFINES_SVH

// check a property at every clock edge outside reset
`define SSE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sseenc assertion failed");

// check a property at every clock edge, reset included
`define SSE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("sseenc assertion failed");

`endif

// ===== src/sseenc_pkg.sv =====
// ----------------------------------------------------------------------------
// sseenc_pkg
// Types, constants and byte helpers of the exchange-file string encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sseenc_pkg;

  localparam int unsigned CodeW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned IdxW  = 4;

  localparam logic [CodeW-1:0] CodeEnd  = 16'h0000;
  localparam logic [CodeW-1:0] CodeTab  = 16'h0009;
  localparam logic [CodeW-1:0] CodeLf   = 16'h000A;
  localparam logic [CodeW-1:0] CodeCr   = 16'h000D;
  localparam logic [CodeW-1:0] CodeApos = 16'h0027;
  localparam logic [CodeW-1:0] CodeBsl  = 16'h005C;

  localparam logic [ByteW-1:0] ChBsl  = 8'h5C;
  localparam logic [ByteW-1:0] ChX    = 8'h58;
  localparam logic [ByteW-1:0] ChZero = 8'h30;
  localparam logic [ByteW-1:0] ChTwo  = 8'h32;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_CLOSE,
    PFX_OPEN
  } prefix_e;

  typedef enum logic [2:0] {
    BODY_NONE,
    BODY_ESC,
    BODY_BSL,
    BODY_CHAR,
    BODY_HEX
  } body_e;

  typedef struct packed {
    prefix_e          prefix;
    body_e            body;
    logic [CodeW-1:0] code;
  } cmd_t;

  function automatic logic [ByteW-1:0] hex_ascii(input logic [3:0] nib);
    logic [ByteW-1:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
  endfunction

  function automatic logic [2:0] body_len(input body_e body);
    logic [2:0] len;
    unique case (body)
      BODY_ESC:  len = 3'd5;
      BODY_BSL:  len = 3'd2;
      BODY_CHAR: len = 3'd1;
      BODY_HEX:  len = 3'd4;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== src/sseenc_front.sv =====
// ----------------------------------------------------------------------------
// sseenc_front
// Classifies each character code, tracks the open hex block and issues one
// byte-sequence command per code that yields output.
// ----------------------------------------------------------------------------
`default_nettype none

module sseenc_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic [sseenc_pkg::CodeW-1:0]   in_code_i,
  output      logic                           in_ready_o,
  output      logic                           push_o,
  output      sseenc_pkg::cmd_t               push_cmd_o,
  input  wire logic                           queue_full_i
);

  logic block_open_q, block_open_d;
  logic accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    block_open_d      = block_open_q;
    push_cmd_o.code   = in_code_i;
    push_cmd_o.prefix = block_open_q ? sseenc_pkg::PFX_CLOSE : sseenc_pkg::PFX_NONE;
    push_cmd_o.body   = sseenc_pkg::BODY_NONE;
    push_o            = accept;
    priority if (in_code_i == sseenc_pkg::CodeEnd) begin
      push_o = accept && block_open_q;
    end else if (in_code_i == sseenc_pkg::CodeTab || in_code_i == sseenc_pkg::CodeLf ||
                 in_code_i == sseenc_pkg::CodeCr  || in_code_i == sseenc_pkg::CodeApos) begin
      push_cmd_o.body = sseenc_pkg::BODY_ESC;
    end else if (in_code_i == sseenc_pkg::CodeBsl) begin
      push_cmd_o.body = sseenc_pkg::BODY_BSL;
    end else if (in_code_i[sseenc_pkg::CodeW-1:7] == '0) begin
      push_cmd_o.body = sseenc_pkg::BODY_CHAR;
    end else begin
      push_cmd_o.body   = sseenc_pkg::BODY_HEX;
      push_cmd_o.prefix = block_open_q ? sseenc_pkg::PFX_NONE : sseenc_pkg::PFX_OPEN;
    end
    if (accept) begin
      block_open_d = (push_cmd_o.body == sseenc_pkg::BODY_HEX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_open_q <= 1'b0;
    end else begin
      block_open_q <= block_open_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/sseenc_queue.sv =====
// ----------------------------------------------------------------------------
// sseenc_queue
// Small register queue of byte-sequence commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sseenc_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sseenc_pkg::cmd_t push_cmd_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic             valid_o,
  output      sseenc_pkg::cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sseenc_pkg::cmd_t slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(Depth - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/sseenc_back.sv =====
// ----------------------------------------------------------------------------
// sseenc_back
// Walks the head command one byte per cycle, while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sseenc_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  input  wire sseenc_pkg::cmd_t              cmd_i,
  output      logic                          pop_o,
  output      logic                          out_valid_o,
  output      logic [sseenc_pkg::ByteW-1:0]  out_byte_o,
  output      logic                          out_last_o,
  input  wire logic                          out_ready_i
);

  logic [sseenc_pkg::IdxW-1:0]  idx_q, idx_d, body_idx_w;
  logic [2:0]                   body_idx, blen;
  logic                         in_prefix, last, load;
  logic [sseenc_pkg::ByteW-1:0] byte_w;
  logic                         out_valid_q, out_valid_d;
  logic [sseenc_pkg::ByteW-1:0] out_byte_q;
  logic                         out_last_q;

  assign load  = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && last;

  always_comb begin
    in_prefix  = (cmd_i.prefix != sseenc_pkg::PFX_NONE) && (idx_q < 4'd4);
    body_idx_w = (cmd_i.prefix != sseenc_pkg::PFX_NONE) ? (idx_q - 4'd4) : idx_q;
    body_idx   = body_idx_w[2:0];
    blen       = sseenc_pkg::body_len(cmd_i.body);
    byte_w     = sseenc_pkg::ChBsl;
    if (in_prefix) begin
      last = (idx_q == 4'd3) && (cmd_i.body == sseenc_pkg::BODY_NONE);
      unique case (idx_q[1:0])
        2'd1:    byte_w = sseenc_pkg::ChX;
        2'd2:    byte_w = (cmd_i.prefix == sseenc_pkg::PFX_OPEN) ? sseenc_pkg::ChTwo
                                                                  : sseenc_pkg::ChZero;
        default: byte_w = sseenc_pkg::ChBsl;
      endcase
    end else begin
      last = (body_idx == blen - 3'd1);
      unique case (cmd_i.body)
        sseenc_pkg::BODY_ESC: begin
          unique case (body_idx)
            3'd1:    byte_w = sseenc_pkg::ChX;
            3'd3:    byte_w = sseenc_pkg::hex_ascii(cmd_i.code[7:4]);
            3'd4:    byte_w = sseenc_pkg::hex_ascii(cmd_i.code[3:0]);
            default: byte_w = sseenc_pkg::ChBsl;
          endcase
        end
        sseenc_pkg::BODY_CHAR: byte_w = cmd_i.code[7:0];
        sseenc_pkg::BODY_HEX: begin
          unique case (body_idx[1:0])
            2'd0:    byte_w = sseenc_pkg::hex_ascii(cmd_i.code[15:12]);
            2'd1:    byte_w = sseenc_pkg::hex_ascii(cmd_i.code[11:8]);
            2'd2:    byte_w = sseenc_pkg::hex_ascii(cmd_i.code[7:4]);
            default: byte_w = sseenc_pkg::hex_ascii(cmd_i.code[3:0]);
          endcase
        end
        default: byte_w = sseenc_pkg::ChBsl;
      endcase
    end
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = last ? '0 : idx_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= byte_w;
      out_last_q <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== src/step_string_escape_encoder_top.sv =====
// ----------------------------------------------------------------------------
// step_string_escape_encoder_top
// Exchange-file string escape encoder: 16-bit codes in, ASCII bytes out.
// ----------------------------------------------------------------------------
// One character code is taken per request and turned into 0 to 9 bytes,
// with tlast on the final byte of each code. A registered output stage
// delivers them and sets the rate: one byte per cycle when not stalled.
// A plain ASCII code yields one byte, so such codes stream at one per
// cycle when not stalled; an escape yields 5 bytes, a backslash 2, a code
// of 128 and above 4 (8 when it opens a hex block), a block close 4 more.
// A command queue of QueueDepth entries lets the input run ahead of a
// longer sequence. An end mark with no open block produces no bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module step_string_escape_encoder_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] code_unit
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output      logic        m_axis_tlast    // last_of_run
);

  logic             push, full, pop, head_valid;
  sseenc_pkg::cmd_t push_cmd, head_cmd;

  sseenc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_code_i    (s_axis_tdata),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .push_cmd_o   (push_cmd),
    .queue_full_i (full)
  );

  sseenc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .head_o     (head_cmd)
  );

  sseenc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

endmodule

`default_nettype wire

// ===== src/sseenc_checker.sv =====
// ----------------------------------------------------------------------------
// sseenc_checker
// Port-level checks of the string encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "step_string_escape_encoder_top_defines.svh"

module sseenc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [15:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tlast
);

  `SSE_ASSERT_ALWAYS(a_idle_in_reset, clk_i, !rst_ni |=> !m_axis_tvalid)

  `SSE_ASSERT(a_ascii_only, clk_i, rst_ni, m_axis_tvalid |-> !m_axis_tdata[7])

  `SSE_ASSERT(a_hold_on_stall, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  `SSE_ASSERT(a_in_hold_on_stall, clk_i, rst_ni,
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))

endmodule

bind step_string_escape_encoder_top sseenc_checker u_sseenc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
